/* rtl/bbc_pkg.sv */
// Shared types and constants of the block buffer cache.
`default_nettype none

package bbc_pkg;

  localparam int unsigned DEF_ENTRIES = 256;
  localparam int unsigned DEF_BUCKETS = 32;
  localparam int unsigned DEF_POOLS   = 16;

  typedef enum logic [1:0] {
    FN_GET       = 2'd0,
    FN_RELEASE   = 2'd1,
    FN_DIRTY     = 2'd2,
    FN_WRITEBACK = 2'd3
  } bbc_func_e;

  typedef enum logic [2:0] {
    STAT_HIT    = 3'd0,
    STAT_MISS   = 3'd1,
    STAT_BUSY   = 3'd2,
    STAT_NOFREE = 3'd3,
    STAT_DONE   = 3'd4
  } bbc_status_e;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_HASH, S_BKT, S_WALK, S_MISS, S_MRD, S_RR1, S_RR2, S_HFIN,
    S_CR1, S_CR2, S_CR3, S_INS0, S_INS1, S_INS2, S_RD, S_AP1, S_AP2, S_AP3, S_RESP
  } bbc_state_e;

  typedef struct packed {
    bbc_func_e   func;
    logic [7:0]  device;
    logic [31:0] block_number;
    logic [3:0]  pool;
    logic [7:0]  buffer_index;
  } bbc_req_t;

  typedef struct packed {
    bbc_status_e status;
    logic [7:0]  granted_buffer;
    logic        needs_fill;
    logic        writeback;
    logic [7:0]  wb_device;
    logic [31:0] wb_block;
    logic [7:0]  wb_buffer;
  } bbc_resp_t;

endpackage

`default_nettype wire

/* rtl/bbc_hash.sv */
// Bucket hash unit: 32-bit value modulo the bucket count, one nibble per cycle.
`default_nettype none

module bbc_hash #(
  parameter int unsigned BUCKETS = bbc_pkg::DEF_BUCKETS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [31:0]                value_i,
  output logic                       done_o,
  output logic [$clog2(BUCKETS)-1:0] bucket_o
);
  import bbc_pkg::*;

  localparam int unsigned BW = $clog2(BUCKETS);
  localparam int unsigned RW = BW + 4;

  logic          run_q, done_q;
  logic [2:0]    cnt_q;
  logic [31:0]   val_q;
  logic [BW-1:0] rem_q, rem_d;
  logic [RW-1:0] acc;

  // Shift the remainder up by a nibble and bring it back below the bucket count.
  always_comb begin
    acc = {rem_q, 4'b0000} + RW'(val_q[31:28]);
    for (int s = 3; s >= 0; s--) begin
      if (acc >= RW'(BUCKETS << s)) begin
        acc = acc - RW'(BUCKETS << s);
      end
    end
    rem_d = acc[BW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 3'd1;
        if (cnt_q == 3'd7) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      val_q <= value_i;
      rem_q <= '0;
    end else if (run_q) begin
      val_q <= {val_q[27:0], 4'b0000};
      rem_q <= rem_d;
    end
  end

  assign done_o   = done_q;
  assign bucket_o = rem_q;

endmodule

`default_nettype wire

/* rtl/bbc_ctrl.sv */
// Sequencer and entry/bucket memories of the block buffer cache.
`default_nettype none

module bbc_ctrl #(
  parameter int unsigned ENTRIES = bbc_pkg::DEF_ENTRIES,
  parameter int unsigned BUCKETS = bbc_pkg::DEF_BUCKETS,
  parameter int unsigned POOLS   = bbc_pkg::DEF_POOLS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       req_valid_i,
  input  bbc_pkg::bbc_req_t          req_i,
  output logic                       req_ready_o,
  output logic                       resp_valid_o,
  output bbc_pkg::bbc_resp_t         resp_o,
  input  logic                       resp_ready_i,
  output logic                       hash_start_o,
  output logic [31:0]                hash_value_o,
  input  logic                       hash_done_i,
  input  logic [$clog2(BUCKETS)-1:0] hash_bucket_i
);
  import bbc_pkg::*;

  localparam int unsigned W     = $clog2(ENTRIES);
  localparam int unsigned BW    = $clog2(BUCKETS);
  localparam int unsigned PW    = (POOLS > 1) ? $clog2(POOLS) : 1;
  localparam int unsigned SHARE = ENTRIES / POOLS;
  localparam int unsigned NCLR  = (ENTRIES > BUCKETS) ? ENTRIES : BUCKETS;
  localparam int unsigned CW    = $clog2(NCLR);

  typedef struct packed {
    logic [7:0]   dev;
    logic [31:0]  blk;
    logic         valid;
    logic         dirty;
    logic         locked;
    logic         linked;
    logic         chn;
    logic [W-1:0] cn;
    logic         chp;
    logic [W-1:0] cp;
    logic [W-1:0] fn;
    logic [W-1:0] fp;
  } ent_t;

  typedef struct packed {
    logic tag, valid, dirty, locked, linked, cnext, cprev, fnext, fprev;
  } ent_wen_t;

  typedef struct packed {
    logic         valid;
    logic [W-1:0] idx;
  } bkt_t;

  // Pool of an entry: the pools are contiguous index ranges of SHARE entries; the last also takes any remainder.
  function automatic logic [4:0] pool_of(input logic [W-1:0] e);
    logic [4:0] p;
    p = '0;
    for (int k = 1; k < int'(POOLS); k++) begin
      if (e >= W'(k * SHARE)) begin
        p = p + 5'd1;
      end
    end
    return p;
  endfunction

  ent_t ent_mem [ENTRIES];
  bkt_t bkt_mem [BUCKETS];

  ent_t          ent_rdata_q, ent_wdata;
  ent_wen_t      wen;
  logic [W-1:0]  ent_waddr, ent_raddr;
  bkt_t          bkt_rdata_q, bkt_wdata;
  logic          bkt_we;
  logic [BW-1:0] bkt_waddr, bkt_raddr;

  bbc_state_e    state_q, state_d;
  bbc_req_t      req_q, req_d;
  bbc_resp_t     resp_q, resp_d;
  logic [W-1:0]  e_q, e_d, hidx_q, hidx_d, t_q, t_d;
  ent_t          ew_q, ew_d;
  bkt_t          hb_q, hb_d;
  logic [BW-1:0] b_q, b_d;
  logic [CW-1:0] clr_q, clr_d;
  logic [W-1:0]  ps_q, ps_d;
  logic [PW-1:0] pc_q, pc_d;

  logic          fh_valid_q [POOLS];
  logic [W-1:0]  fh_idx_q   [POOLS];
  logic [PW-1:0] pidx;
  logic          fh_set_valid, fh_valid_val, fh_set_idx;
  logic [W-1:0]  fh_idx_val;

  logic          clr_in_ent, clr_in_bkt, pool_ok;
  logic [W-1:0]  ci, clast;

  always_ff @(posedge clk_i) begin
    if (wen.tag) begin
      ent_mem[ent_waddr].dev <= ent_wdata.dev;
      ent_mem[ent_waddr].blk <= ent_wdata.blk;
    end
    if (wen.valid)  ent_mem[ent_waddr].valid  <= ent_wdata.valid;
    if (wen.dirty)  ent_mem[ent_waddr].dirty  <= ent_wdata.dirty;
    if (wen.locked) ent_mem[ent_waddr].locked <= ent_wdata.locked;
    if (wen.linked) ent_mem[ent_waddr].linked <= ent_wdata.linked;
    if (wen.cnext) begin
      ent_mem[ent_waddr].chn <= ent_wdata.chn;
      ent_mem[ent_waddr].cn  <= ent_wdata.cn;
    end
    if (wen.cprev) begin
      ent_mem[ent_waddr].chp <= ent_wdata.chp;
      ent_mem[ent_waddr].cp  <= ent_wdata.cp;
    end
    if (wen.fnext) ent_mem[ent_waddr].fn <= ent_wdata.fn;
    if (wen.fprev) ent_mem[ent_waddr].fp <= ent_wdata.fp;
    ent_rdata_q <= ent_mem[ent_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (bkt_we) begin
      bkt_mem[bkt_waddr] <= bkt_wdata;
    end
    bkt_rdata_q <= bkt_mem[bkt_raddr];
  end

  assign pidx = (req_q.func == FN_GET) ? PW'(req_q.pool) : PW'(pool_of(e_q));

  assign clr_in_ent = {1'b0, clr_q} < (CW + 1)'(ENTRIES);
  assign clr_in_bkt = {1'b0, clr_q} < (CW + 1)'(BUCKETS);
  assign ci         = clr_q[W-1:0];
  assign clast      = (pc_q == PW'(POOLS - 1)) ? W'(ENTRIES - 1) : W'(ps_q + SHARE - 1);
  assign pool_ok    = {1'b0, req_q.pool} < 5'(POOLS);

  always_comb begin
    state_d      = state_q;
    req_d        = req_q;
    resp_d       = resp_q;
    e_d          = e_q;
    ew_d         = ew_q;
    hb_d         = hb_q;
    hidx_d       = hidx_q;
    t_d          = t_q;
    b_d          = b_q;
    clr_d        = clr_q;
    ps_d         = ps_q;
    pc_d         = pc_q;
    wen          = '0;
    ent_waddr    = e_q;
    ent_wdata    = '0;
    ent_raddr    = e_q;
    bkt_we       = 1'b0;
    bkt_waddr    = b_q;
    bkt_wdata    = '0;
    bkt_raddr    = b_q;
    fh_set_valid = 1'b0;
    fh_valid_val = 1'b0;
    fh_set_idx   = 1'b0;
    fh_idx_val   = e_q;
    hash_start_o = 1'b0;
    hash_value_o = {24'b0, ew_q.dev} ^ ew_q.blk;
    req_ready_o  = 1'b0;
    resp_valid_o = 1'b0;

    case (state_q)
      S_CLEAR: begin
        // Each pool's entries form a ring in index order.
        if (clr_in_ent) begin
          wen          = '1;
          ent_waddr    = ci;
          ent_wdata.fn = (ci == clast) ? ps_q : W'(ci + 1'b1);
          ent_wdata.fp = (ci == ps_q) ? clast : W'(ci - 1'b1);
          if (ci == clast && pc_q != PW'(POOLS - 1)) begin
            pc_d = pc_q + 1'b1;
            ps_d = W'(ci + 1'b1);
          end
        end
        if (clr_in_bkt) begin
          bkt_we    = 1'b1;
          bkt_waddr = clr_q[BW-1:0];
        end
        clr_d = clr_q + 1'b1;
        if (clr_q == CW'(NCLR - 1)) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          req_d         = req_i;
          resp_d        = '0;
          resp_d.status = STAT_DONE;
          e_d           = W'(req_i.buffer_index);
          if (req_i.func == FN_GET) begin
            hash_start_o = 1'b1;
            hash_value_o = {24'b0, req_i.device} ^ req_i.block_number;
            state_d      = S_HASH;
          end else if (11'(req_i.buffer_index) >= 11'(ENTRIES)) begin
            state_d = S_RESP;
          end else if (req_i.func == FN_DIRTY) begin
            wen.dirty       = 1'b1;
            ent_waddr       = W'(req_i.buffer_index);
            ent_wdata.dirty = 1'b1;
            state_d         = S_RESP;
          end else begin
            ent_raddr = W'(req_i.buffer_index);
            state_d   = S_RD;
          end
        end
      end

      S_HASH: begin
        if (hash_done_i) begin
          b_d       = hash_bucket_i;
          bkt_raddr = hash_bucket_i;
          state_d   = S_BKT;
        end
      end

      S_BKT: begin
        if (bkt_rdata_q.valid) begin
          e_d       = bkt_rdata_q.idx;
          ent_raddr = bkt_rdata_q.idx;
          state_d   = S_WALK;
        end else begin
          state_d = S_MISS;
        end
      end

      S_WALK: begin
        if (ent_rdata_q.dev == req_q.device && ent_rdata_q.blk == req_q.block_number &&
            pool_of(e_q) == {1'b0, req_q.pool}) begin
          ew_d                  = ent_rdata_q;
          resp_d.granted_buffer = 8'(e_q);
          if (ent_rdata_q.locked) begin
            resp_d.status = STAT_BUSY;
            state_d       = S_RESP;
          end else begin
            resp_d.status     = STAT_HIT;
            resp_d.needs_fill = !ent_rdata_q.valid;
            state_d           = S_RR1;
          end
        end else if (ent_rdata_q.chn) begin
          e_d       = ent_rdata_q.cn;
          ent_raddr = ent_rdata_q.cn;
        end else begin
          state_d = S_MISS;
        end
      end

      S_MISS: begin
        if (!pool_ok || !fh_valid_q[pidx]) begin
          resp_d.status = STAT_NOFREE;
          state_d       = S_RESP;
        end else begin
          e_d       = fh_idx_q[pidx];
          ent_raddr = fh_idx_q[pidx];
          state_d   = S_MRD;
        end
      end

      S_MRD: begin
        ew_d                  = ent_rdata_q;
        resp_d.status         = STAT_MISS;
        resp_d.granted_buffer = 8'(e_q);
        resp_d.needs_fill     = 1'b1;
        if (ent_rdata_q.dirty) begin
          resp_d.writeback = 1'b1;
          resp_d.wb_device = ent_rdata_q.dev;
          resp_d.wb_block  = ent_rdata_q.blk;
          resp_d.wb_buffer = 8'(e_q);
        end
        state_d = S_RR1;
      end

      // Unlink the entry from its pool's free ring.
      S_RR1: begin
        if (ew_q.fn == e_q) begin
          fh_set_valid = 1'b1;
          fh_valid_val = 1'b0;
        end else begin
          wen.fnext    = 1'b1;
          ent_waddr    = ew_q.fp;
          ent_wdata.fn = ew_q.fn;
          if (fh_idx_q[pidx] == e_q) begin
            fh_set_idx = 1'b1;
            fh_idx_val = ew_q.fn;
          end
        end
        state_d = S_RR2;
      end

      S_RR2: begin
        if (ew_q.fn != e_q) begin
          wen.fprev    = 1'b1;
          ent_waddr    = ew_q.fn;
          ent_wdata.fp = ew_q.fp;
        end
        state_d = (resp_q.status == STAT_HIT) ? S_HFIN : S_CR1;
      end

      S_HFIN: begin
        wen.valid        = 1'b1;
        wen.locked       = 1'b1;
        ent_wdata.valid  = 1'b1;
        ent_wdata.locked = 1'b1;
        state_d          = S_RESP;
      end

      // Unlink the victim from its old hash chain.
      S_CR1: begin
        if (ew_q.linked && ew_q.chn) begin
          wen.cprev     = 1'b1;
          ent_waddr     = ew_q.cn;
          ent_wdata.chp = ew_q.chp;
          ent_wdata.cp  = ew_q.cp;
        end
        state_d = S_CR2;
      end

      S_CR2: begin
        if (ew_q.linked && ew_q.chp) begin
          wen.cnext     = 1'b1;
          ent_waddr     = ew_q.cp;
          ent_wdata.chn = ew_q.chn;
          ent_wdata.cn  = ew_q.cn;
          state_d       = S_INS0;
        end else if (ew_q.linked) begin
          hash_start_o = 1'b1;
          state_d      = S_CR3;
        end else begin
          state_d = S_INS0;
        end
      end

      S_CR3: begin
        // The victim heads its old chain, so the chain's head moves on.
        if (hash_done_i) begin
          bkt_we          = 1'b1;
          bkt_waddr       = hash_bucket_i;
          bkt_wdata.valid = ew_q.chn;
          bkt_wdata.idx   = ew_q.chn ? ew_q.cn : '0;
          state_d         = S_INS0;
        end
      end

      S_INS0: begin
        state_d = S_INS1;
      end

      S_INS1: begin
        hb_d             = bkt_rdata_q;
        wen              = '1;
        wen.fnext        = 1'b0;
        wen.fprev        = 1'b0;
        ent_wdata.dev    = req_q.device;
        ent_wdata.blk    = req_q.block_number;
        ent_wdata.valid  = 1'b1;
        ent_wdata.locked = 1'b1;
        ent_wdata.linked = 1'b1;
        ent_wdata.chn    = bkt_rdata_q.valid;
        ent_wdata.cn     = bkt_rdata_q.valid ? bkt_rdata_q.idx : '0;
        bkt_we           = 1'b1;
        bkt_wdata.valid  = 1'b1;
        bkt_wdata.idx    = e_q;
        state_d          = S_INS2;
      end

      S_INS2: begin
        if (hb_q.valid) begin
          wen.cprev     = 1'b1;
          ent_waddr     = hb_q.idx;
          ent_wdata.chp = 1'b1;
          ent_wdata.cp  = e_q;
        end
        state_d = S_RESP;
      end

      S_RD: begin
        ew_d    = ent_rdata_q;
        state_d = S_RESP;
        if (req_q.func == FN_WRITEBACK) begin
          resp_d.writeback = 1'b1;
          resp_d.wb_device = ent_rdata_q.dev;
          resp_d.wb_block  = ent_rdata_q.blk;
          resp_d.wb_buffer = 8'(e_q);
          wen.dirty        = 1'b1;
        end else if (ent_rdata_q.locked) begin
          if (!fh_valid_q[pidx]) begin
            fh_set_valid = 1'b1;
            fh_valid_val = 1'b1;
            fh_set_idx   = 1'b1;
            wen.fnext    = 1'b1;
            wen.fprev    = 1'b1;
            wen.locked   = 1'b1;
            ent_wdata.fn = e_q;
            ent_wdata.fp = e_q;
          end else begin
            hidx_d    = fh_idx_q[pidx];
            ent_raddr = fh_idx_q[pidx];
            state_d   = S_AP1;
          end
        end
      end

      // Append the released entry at the ring's tail, just before the head.
      S_AP1: begin
        t_d          = ent_rdata_q.fp;
        wen.fnext    = 1'b1;
        wen.fprev    = 1'b1;
        wen.locked   = 1'b1;
        ent_wdata.fn = hidx_q;
        ent_wdata.fp = ent_rdata_q.fp;
        state_d      = S_AP2;
      end

      S_AP2: begin
        wen.fnext    = 1'b1;
        ent_waddr    = t_q;
        ent_wdata.fn = e_q;
        state_d      = S_AP3;
      end

      S_AP3: begin
        wen.fprev    = 1'b1;
        ent_waddr    = hidx_q;
        ent_wdata.fp = e_q;
        state_d      = S_RESP;
      end

      S_RESP: begin
        resp_valid_o = 1'b1;
        if (resp_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign resp_o = resp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      ps_q    <= '0;
      pc_q    <= '0;
      for (int p = 0; p < int'(POOLS); p++) begin
        fh_valid_q[p] <= 1'b1;
        fh_idx_q[p]   <= W'(p * SHARE);
      end
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      ps_q    <= ps_d;
      pc_q    <= pc_d;
      if (fh_set_valid) fh_valid_q[pidx] <= fh_valid_val;
      if (fh_set_idx)   fh_idx_q[pidx]   <= fh_idx_val;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    resp_q <= resp_d;
    e_q    <= e_d;
    ew_q   <= ew_d;
    hb_q   <= hb_d;
    hidx_q <= hidx_d;
    t_q    <= t_d;
    b_q    <= b_d;
  end

endmodule

`default_nettype wire

/* rtl/block_buffer_cache.sv */
// Top level of the block buffer cache: stream ports, output register and units.
`default_nettype none

// Block buffer cache with ENTRIES buffer entries split evenly into POOLS pools.
// Each input beat is one request: get a block (device, block number, pool),
// release an entry, mark it dirty or write it back; each request yields exactly
// one result beat. Requests are served one at a time. A get runs the hash unit,
// which reduces device xor block modulo BUCKETS one nibble per cycle, reads the
// bucket and walks its hash chain, each step a read of the entry memory. A hit
// unlinks the entry from its pool's free ring and locks it; a miss unlinks the
// free ring's head from that ring and its old chain (with a second hash pass if
// it heads that chain) and puts it at the new chain's head, one linked-list update
// per cycle outside the hash pass. Mark dirty sets the dirty bit, write back
// reports the entry and clears its dirty bit, and release puts a locked entry back
// into its pool's free ring, at its tail if the ring is not empty. After reset a
// clearing pass builds the free rings and empties the hash chains; no request beat
// is accepted before it ends. The result sits in an output register, so the next
// request is taken while a finished result still waits on the master side.
module block_buffer_cache #(
  parameter int unsigned ENTRIES = bbc_pkg::DEF_ENTRIES,
  parameter int unsigned BUCKETS = bbc_pkg::DEF_BUCKETS,
  parameter int unsigned POOLS   = bbc_pkg::DEF_POOLS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // device [7:0], block_number [39:8], pool [43:40], buffer_index [51:44]
  input  logic [55:0] s_axis_tdata,
  // func [1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // granted_buffer [7:0], needs_fill [8], writeback [9], wb_device [17:10],
  // wb_block [49:18], wb_buffer [57:50]
  output logic [63:0] m_axis_tdata,
  // status [2:0]
  output logic [2:0]  m_axis_tuser
);
  import bbc_pkg::*;

  bbc_req_t                req;
  bbc_resp_t               resp, out_q;
  logic                    resp_valid, resp_ready, out_valid_q;
  logic                    hash_start, hash_done;
  logic [31:0]             hash_value;
  logic [$clog2(BUCKETS)-1:0] hash_bucket;

  assign req.func         = bbc_func_e'(s_axis_tuser);
  assign req.device       = s_axis_tdata[7:0];
  assign req.block_number = s_axis_tdata[39:8];
  assign req.pool         = s_axis_tdata[43:40];
  assign req.buffer_index = s_axis_tdata[51:44];

  bbc_hash #(
    .BUCKETS(BUCKETS)
  ) u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (hash_start),
    .value_i (hash_value),
    .done_o  (hash_done),
    .bucket_o(hash_bucket)
  );

  bbc_ctrl #(
    .ENTRIES(ENTRIES),
    .BUCKETS(BUCKETS),
    .POOLS  (POOLS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (s_axis_tvalid),
    .req_i        (req),
    .req_ready_o  (s_axis_tready),
    .resp_valid_o (resp_valid),
    .resp_o       (resp),
    .resp_ready_i (resp_ready),
    .hash_start_o (hash_start),
    .hash_value_o (hash_value),
    .hash_done_i  (hash_done),
    .hash_bucket_i(hash_bucket)
  );

  // The output register takes a new result whenever it is empty or being drained.
  assign resp_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (resp_valid && resp_ready) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (resp_valid && resp_ready) begin
      out_q <= resp;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tdata  = {6'b0, out_q.wb_buffer, out_q.wb_block, out_q.wb_device,
                          out_q.writeback, out_q.needs_fill, out_q.granted_buffer};

endmodule

`default_nettype wire

/* rtl/bbc_checker.sv */
// Port-level checks of the block buffer cache and their binding.
`default_nettype none

module bbc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser
);
  import bbc_pkg::*;

  // A waiting result beat is held unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  // Only a miss or a write back asks for a writeback.
  a_wb_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[9] |-> m_axis_tuser == STAT_MISS
      || m_axis_tuser == STAT_DONE)
    else $error("writeback on a result that cannot carry one");

  // A miss always hands out an entry that must be filled.
  a_miss_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == STAT_MISS |-> m_axis_tdata[8])
    else $error("miss without fill request");

  // A refused get grants nothing.
  a_nofree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == STAT_NOFREE |-> m_axis_tdata[9:0] == 10'd0)
    else $error("no-free result carries a grant");

  // Requests are served one at a time, so a new request cannot be taken in
  // the cycle straight after one was accepted.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request accepted on consecutive cycles");

endmodule

bind block_buffer_cache bbc_checker u_bbc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);

`default_nettype wire
